@@ sv/multi_tap_echo_macros.svh @@
// Assertion macros for the multi-tap echo checker.
// No dependencies; included by files that assert.
`ifndef MULTI_TAP_ECHO_MACROS_SVH
`define MULTI_TAP_ECHO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mte_pkg.sv @@
// Shared constants and types for the multi-tap echo block.
// No dependencies; used by multi_tap_echo and its checker.
`timescale 1ns / 1ps

package mte_pkg;

    // Delay ring geometry (power of two depth)
    localparam int RING_DEPTH = 32768;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    // Sample and register widths
    localparam int SAMPLE_W   = 16;
    localparam int REG_W      = 15;
    localparam int CFG_IDX_W  = 3;

    // Arithmetic widths: gain (unsigned) times sample, three-term sum at Q3.30
    localparam int FRAC_W     = 15;
    localparam int PROD_W     = SAMPLE_W + REG_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int ECHO_W     = ACC_W - FRAC_W;
    localparam int SUM_W      = ECHO_W + 1;
    localparam int SAT_MAX    = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAT_MIN    = -(2 ** (SAMPLE_W - 1));
    localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(2 ** (FRAC_W - 1));

    // Result queue
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int CREDIT_W   = $clog2(OUT_DEPTH + 1);

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [REG_W-1:0]           t_reg;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_SHORT = 3'd0,
        CFG_DELAY_MID   = 3'd1,
        CFG_DELAY_LONG  = 3'd2,
        CFG_GAIN_SHORT  = 3'd3,
        CFG_GAIN_MID    = 3'd4,
        CFG_GAIN_LONG   = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam t_reg DELAY_SHORT_RST = 15'd5591;
    localparam t_reg DELAY_MID_RST   = 15'd12206;
    localparam t_reg DELAY_LONG_RST  = 15'd21026;
    localparam t_reg GAIN_SHORT_RST  = 15'd5898;
    localparam t_reg GAIN_MID_RST    = 15'd3932;
    localparam t_reg GAIN_LONG_RST   = 15'd1966;

endpackage

@@ sv/multi_tap_echo.sv @@
// Multi-tap feedforward echo: stereo in, mono plus three weighted echoes out.
// Depends on mte_pkg; the ring memory and result queue live in this module.
`timescale 1ns / 1ps

// Accepts a new stereo pair when idle or while the previous pair is written, and
// returns one saturated mono result per pair. The spacing between input pairs
// is set by the single port pair of the delay ring memory: each pair
// takes three tap reads and one write of the new mono value. The ring starts as
// all zero after reset with no clearing pass: a fill mark tracks which entries
// have been written since reset, so the block takes input in the first cycle
// after reset. Results wait in a four-entry queue, so input keeps flowing
// while the output side stalls until four results are outstanding.
// Configuration writes are taken in any cycle but must come while the block
// is idle; an index above five is ignored.
module multi_tap_echo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Stereo input: [15:0] left_sample, [31:16] right_sample
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*mte_pkg::SAMPLE_W-1:0]      s_axis_tdata,
    // Mono output: [15:0] mono_out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mte_pkg::SAMPLE_W-1:0]        m_axis_tdata,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [mte_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mte_pkg::REG_W-1:0]           i_cfg_data
);

    // Sequencer states; also used as the tap tag in the arithmetic pipeline
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHORT,
        ST_MID,
        ST_LONG,
        ST_WRITE
    } t_state;

    // Configuration registers
    mte_pkg::t_reg r_delay_short, r_delay_mid, r_delay_long;
    mte_pkg::t_reg r_gain_short, r_gain_mid, r_gain_long;

    // Sequencer
    t_state            r_state;
    mte_pkg::t_addr    r_wp;
    logic              r_wrapped;
    mte_pkg::t_sample  r_mono;

    // Input side
    logic                                 in_fire;
    mte_pkg::t_sample                     in_left, in_right;
    logic signed [mte_pkg::SAMPLE_W:0]    in_sum;
    mte_pkg::t_sample                     in_mono;

    // Ring access
    mte_pkg::t_sample  r_ring_mem [mte_pkg::RING_DEPTH];
    mte_pkg::t_sample  r_rd_data;
    mte_pkg::t_reg     rd_delay;
    mte_pkg::t_addr    rd_addr;
    logic              rd_en, rd_live, wr_en;

    // Read-data stage
    logic              r_s1_valid;
    t_state            r_s1_tap;
    logic              r_s1_live;
    mte_pkg::t_sample  r_s1_mono;

    // Product stage
    mte_pkg::t_sample                        tap_val;
    mte_pkg::t_reg                           tap_gain;
    logic signed [mte_pkg::PROD_W:0]         prod_full;
    logic                                    r_s2_valid;
    t_state                                  r_s2_tap;
    logic signed [mte_pkg::PROD_W-1:0]       r_s2_prod;
    mte_pkg::t_sample                        r_s2_mono;

    // Accumulate stage
    logic signed [mte_pkg::ACC_W-1:0]        acc_base, n_acc, r_acc;
    logic                                    r_fin_valid;
    mte_pkg::t_sample                        r_fin_mono;

    // Final stage
    logic signed [mte_pkg::ECHO_W-1:0]       fin_echo;
    logic signed [mte_pkg::SUM_W-1:0]        fin_sum;
    mte_pkg::t_sample                        fin_y;

    // Result queue and credit
    mte_pkg::t_sample                        r_q_data [mte_pkg::OUT_DEPTH];
    logic [mte_pkg::OUT_PTR_W-1:0]           r_q_wr, r_q_rd;
    logic [mte_pkg::CREDIT_W-1:0]            r_q_count, r_credit;
    logic                                    out_fire;

    // Configuration writes; unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_short <= mte_pkg::DELAY_SHORT_RST;
            r_delay_mid   <= mte_pkg::DELAY_MID_RST;
            r_delay_long  <= mte_pkg::DELAY_LONG_RST;
            r_gain_short  <= mte_pkg::GAIN_SHORT_RST;
            r_gain_mid    <= mte_pkg::GAIN_MID_RST;
            r_gain_long   <= mte_pkg::GAIN_LONG_RST;
        end else if (i_cfg_wr_en) begin
            case (mte_pkg::t_cfg_idx'(i_cfg_index))
                mte_pkg::CFG_DELAY_SHORT: r_delay_short <= i_cfg_data;
                mte_pkg::CFG_DELAY_MID:   r_delay_mid   <= i_cfg_data;
                mte_pkg::CFG_DELAY_LONG:  r_delay_long  <= i_cfg_data;
                mte_pkg::CFG_GAIN_SHORT:  r_gain_short  <= i_cfg_data;
                mte_pkg::CFG_GAIN_MID:    r_gain_mid    <= i_cfg_data;
                mte_pkg::CFG_GAIN_LONG:   r_gain_long   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a new pair when the ring port frees up and a queue slot is free to reserve
    assign s_axis_tready = ((r_state == ST_IDLE) || (r_state == ST_WRITE)) &&
                           (r_credit != mte_pkg::CREDIT_W'(mte_pkg::OUT_DEPTH));
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Average to mono, rounding toward minus infinity
    assign in_left  = s_axis_tdata[mte_pkg::SAMPLE_W-1:0];
    assign in_right = s_axis_tdata[2*mte_pkg::SAMPLE_W-1:mte_pkg::SAMPLE_W];
    assign in_sum   = (mte_pkg::SAMPLE_W+1)'(in_left) + (mte_pkg::SAMPLE_W+1)'(in_right);
    assign in_mono  = in_sum[mte_pkg::SAMPLE_W:1];

    // Sequence three tap reads then the write; advance the pointer on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE:  if (in_fire) r_state <= ST_SHORT;
                ST_SHORT: r_state <= ST_MID;
                ST_MID:   r_state <= ST_LONG;
                ST_LONG:  r_state <= ST_WRITE;
                ST_WRITE: begin
                    r_state <= in_fire ? ST_SHORT : ST_IDLE;
                    r_wp    <= r_wp + 1'b1;
                    if (r_wp == mte_pkg::ADDR_W'(mte_pkg::RING_DEPTH - 1)) r_wrapped <= 1'b1;
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the mono value of the item in flight
    always_ff @(posedge i_clk) begin
        if (in_fire) r_mono <= in_mono;
    end

    // Tap address; entries not yet written since reset read as zero
    always_comb begin
        case (r_state)
            ST_SHORT: rd_delay = r_delay_short;
            ST_MID:   rd_delay = r_delay_mid;
            default:  rd_delay = r_delay_long;
        endcase
    end
    assign rd_en   = (r_state == ST_SHORT) || (r_state == ST_MID) || (r_state == ST_LONG);
    assign wr_en   = (r_state == ST_WRITE);
    assign rd_addr = r_wp - mte_pkg::ADDR_W'(rd_delay);
    assign rd_live = r_wrapped || (rd_addr < r_wp);

    // Delay ring: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) r_ring_mem[r_wp] <= r_mono;
        if (rd_en) r_rd_data <= r_ring_mem[rd_addr];
    end

    // Tag the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= rd_en;
        end
        r_s1_tap  <= r_state;
        r_s1_live <= rd_live;
        r_s1_mono <= r_mono;
    end

    // Weight the tap by its gain
    always_comb begin
        case (r_s1_tap)
            ST_SHORT: tap_gain = r_gain_short;
            ST_MID:   tap_gain = r_gain_mid;
            default:  tap_gain = r_gain_long;
        endcase
    end
    assign tap_val   = r_s1_live ? r_rd_data : '0;
    assign prod_full = $signed({1'b0, tap_gain}) * tap_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_tap  <= r_s1_tap;
        r_s2_prod <= prod_full[mte_pkg::PROD_W-1:0];
        r_s2_mono <= r_s1_mono;
    end

    // Accumulate; the first tap seeds the rounding bias
    assign acc_base = (r_s2_tap == ST_SHORT) ? mte_pkg::ACC_ROUND : r_acc;
    assign n_acc    = acc_base + mte_pkg::ACC_W'(r_s2_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= r_s2_valid && (r_s2_tap == ST_LONG);
        end
        if (r_s2_valid) r_acc <= n_acc;
        r_fin_mono <= r_s2_mono;
    end

    // Scale back to Q3.15, add the dry signal and saturate to Q1.15
    assign fin_echo = r_acc[mte_pkg::ACC_W-1:mte_pkg::FRAC_W];
    assign fin_sum  = mte_pkg::SUM_W'(r_fin_mono) + mte_pkg::SUM_W'(fin_echo);

    always_comb begin
        if (fin_sum > mte_pkg::SUM_W'(mte_pkg::SAT_MAX)) begin
            fin_y = mte_pkg::SAMPLE_W'(mte_pkg::SAT_MAX);
        end else if (fin_sum < mte_pkg::SUM_W'(mte_pkg::SAT_MIN)) begin
            fin_y = mte_pkg::SAMPLE_W'(mte_pkg::SAT_MIN);
        end else begin
            fin_y = fin_sum[mte_pkg::SAMPLE_W-1:0];
        end
    end

    // Result queue; credit counts accepted transactions not yet delivered
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_q_count != '0);
    assign m_axis_tdata  = r_q_data[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
            r_credit  <= '0;
        end else begin
            if (r_fin_valid) r_q_wr <= r_q_wr + 1'b1;
            if (out_fire)    r_q_rd <= r_q_rd + 1'b1;
            r_q_count <= r_q_count + mte_pkg::CREDIT_W'(r_fin_valid)
                                   - mte_pkg::CREDIT_W'(out_fire);
            r_credit  <= r_credit + mte_pkg::CREDIT_W'(in_fire)
                                  - mte_pkg::CREDIT_W'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_valid) r_q_data[r_q_wr] <= fin_y;
    end

endmodule

@@ sv/mte_checker.sv @@
// Port-level checker for multi_tap_echo, bound into every multi_tap_echo instance.
// Depends on mte_pkg and multi_tap_echo_macros.svh.
`timescale 1ns / 1ps
`include "multi_tap_echo_macros.svh"

module mte_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mte_pkg::SAMPLE_W-1:0]    m_axis_tdata
);

    logic                          s_fire, m_fire;
    logic [mte_pkg::CREDIT_W-1:0]  r_outstanding;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // Track transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + mte_pkg::CREDIT_W'(s_fire)
                                           - mte_pkg::CREDIT_W'(m_fire);
        end
    end

    // A stalled result holds
    `MTE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // No input is accepted while the tap reads of the last one are under way
    `MTE_ASSERT_NXT(a_in_spacing, i_clk, i_rst_n, s_fire, !s_fire ##1 !s_fire ##1 !s_fire, "input accepted faster than the ring allows")

    // No result without an outstanding input
    `MTE_ASSERT_IMP(a_no_orphan, i_clk, i_rst_n, m_axis_tvalid, r_outstanding != '0, "result shown with nothing outstanding")

    // Input stops when the result queue is fully reserved
    `MTE_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, r_outstanding == mte_pkg::CREDIT_W'(mte_pkg::OUT_DEPTH), !s_axis_tready, "input ready with result queue full")

endmodule

bind multi_tap_echo mte_checker u_mte_checker (.*);
